// File: hw/rtl/lmts_pkg.sv
`default_nettype none

package lmts_pkg;

   // Display mode codes, as reported on the result channel
   typedef enum logic [1:0] {
      MODE_HORZ_BLANK = 2'd0,
      MODE_VERT_BLANK = 2'd1,
      MODE_OBJ_SCAN   = 2'd2,
      MODE_XFER       = 2'd3
   } lcd_mode_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_LCD_ENABLE        = 3'd0,
      CSR_HBLANK_IRQ_ENABLE = 3'd1,
      CSR_VBLANK_IRQ_ENABLE = 3'd2,
      CSR_OAM_IRQ_ENABLE    = 3'd3,
      CSR_LINE_IRQ_ENABLE   = 3'd4,
      CSR_MATCH_ON_EQUAL    = 3'd5,
      CSR_COMPARE_LINE      = 3'd6
   } csr_index_type;

   localparam int unsigned DOT_W  = 10;
   localparam int unsigned LINE_W = 8;
   localparam int unsigned ELAP_W = 8;

   // Phase lengths in dots
   localparam logic [DOT_W-1:0] LEN_OAM    = 10'd80;
   localparam logic [DOT_W-1:0] LEN_XFER   = 10'd172;
   localparam logic [DOT_W-1:0] LEN_HBLANK = 10'd204;
   localparam logic [DOT_W-1:0] LEN_LINE   = 10'd456;

   // Line numbers
   localparam logic [LINE_W-1:0] FIRST_VBLANK_LINE = 8'd144;
   localparam logic [LINE_W-1:0] LAST_LINE         = 8'd153;

endpackage

`default_nettype wire

// File: hw/rtl/lcd_mode_timing_sequencer_unit.sv
// LCD mode timing sequencer.
// Request channel (req_*): one item per step carries the time, in dots, elapsed
// since the previous step. It is taken at an edge with req_valid high and
// req_stall low.
// Response channel (rsp_*): one item per request with the display mode, the
// current line and the render, frame-done and interrupt-flag pulses. It is
// taken at an edge with rsp_valid high and rsp_stall low.
// Configuration (csr_*): always ready; the user must write it only while
// the block is idle; the block does not enforce this. A request is held in
// the input register, then its response in the result register. Throughput
// is one item per clock while rsp_stall is low; the dot/line/mode update is
// a single add and compare per cycle. When the receiver stalls, the response
// holds and one more request can wait in the input register; after that
// req_stall rises. Reset clears the timing state (hblank, dot 0, line 0),
// all configuration registers and both valid flags.
`default_nettype none

module lcd_mode_timing_sequencer_unit
   import lmts_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [ELAP_W-1:0] req_elapsed_cycles,
   // response channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [1:0]             rsp_lcd_mode,
   output logic [LINE_W-1:0]      rsp_current_line,
   output logic                   rsp_line_render_pulse,
   output logic                   rsp_frame_done_pulse,
   output logic                   rsp_irq_flag_write,
   output logic                   rsp_irq_flag_value,
   // configuration port
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [7:0]        csr_wdata
);

   // configuration registers
   logic              lcd_enable_ff;
   logic              hblank_irq_en_ff;
   logic              vblank_irq_en_ff;
   logic              oam_irq_en_ff;
   logic              line_irq_en_ff;
   logic              match_on_equal_ff;
   logic [LINE_W-1:0] compare_line_ff;

   // timing state
   lcd_mode_type      mode_ff, mode_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [LINE_W-1:0] line_ff, line_in;

   // input stage
   logic              in_valid_ff, in_valid_in;
   logic [ELAP_W-1:0] elapsed_ff;

   // result stage
   logic              out_valid_ff, out_valid_in;
   logic [1:0]        out_mode_ff;
   logic [LINE_W-1:0] out_line_ff;
   logic              out_render_ff, out_frame_ff, out_wr_ff, out_val_ff;

   // step logic
   logic              in_load, out_load;
   logic [DOT_W-1:0]  dot_sum;
   logic [LINE_W-1:0] line_next;
   logic              line_eq, line_irq_val;
   logic              render, frame, wr, val;

   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         lcd_enable_ff     <= 1'b0;
         hblank_irq_en_ff  <= 1'b0;
         vblank_irq_en_ff  <= 1'b0;
         oam_irq_en_ff     <= 1'b0;
         line_irq_en_ff    <= 1'b0;
         match_on_equal_ff <= 1'b0;
         compare_line_ff   <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LCD_ENABLE:        lcd_enable_ff     <= csr_wdata[0];
            CSR_HBLANK_IRQ_ENABLE: hblank_irq_en_ff  <= csr_wdata[0];
            CSR_VBLANK_IRQ_ENABLE: vblank_irq_en_ff  <= csr_wdata[0];
            CSR_OAM_IRQ_ENABLE:    oam_irq_en_ff     <= csr_wdata[0];
            CSR_LINE_IRQ_ENABLE:   line_irq_en_ff    <= csr_wdata[0];
            CSR_MATCH_ON_EQUAL:    match_on_equal_ff <= csr_wdata[0];
            CSR_COMPARE_LINE:      compare_line_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: the result register frees up when empty or when taken
   assign out_load     = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall    = in_valid_ff && !out_load;
   assign in_load      = req_valid && !req_stall;
   assign in_valid_in  = in_load || (in_valid_ff && !out_load);
   assign out_valid_in = out_load || (out_valid_ff && rsp_stall);

   // One timing step
   assign dot_sum      = dot_ff + {{(DOT_W-ELAP_W){1'b0}}, elapsed_ff};
   assign line_next    = line_ff + 1'b1;
   assign line_eq      = (line_next == compare_line_ff);
   assign line_irq_val = match_on_equal_ff ? line_eq : !line_eq;

   always_comb begin
      mode_in = mode_ff;
      dot_in  = dot_ff;
      line_in = line_ff;
      render  = 1'b0;
      frame   = 1'b0;
      wr      = 1'b0;
      val     = 1'b0;
      if (!lcd_enable_ff) begin
         mode_in = MODE_VERT_BLANK;
         line_in = '0;
      end else begin
         dot_in = dot_sum;
         case (mode_ff)
            MODE_HORZ_BLANK: begin
               if (dot_sum >= LEN_HBLANK) begin
                  dot_in  = '0;
                  line_in = line_next;
                  if (line_irq_en_ff) begin
                     wr  = 1'b1;
                     val = line_irq_val;
                  end
                  if (line_next == FIRST_VBLANK_LINE) begin
                     mode_in = MODE_VERT_BLANK;
                     frame   = 1'b1;
                     if (vblank_irq_en_ff) begin
                        wr  = 1'b1;
                        val = 1'b1;
                     end
                  end else begin
                     mode_in = MODE_OBJ_SCAN;
                     if (oam_irq_en_ff) begin
                        wr  = 1'b1;
                        val = 1'b1;
                     end
                  end
               end
            end
            MODE_VERT_BLANK: begin
               if (dot_sum >= LEN_LINE) begin
                  dot_in  = '0;
                  line_in = line_next;
                  if (line_irq_en_ff) begin
                     wr  = 1'b1;
                     val = line_irq_val;
                  end
                  // wrap after the last vblank line
                  if (line_next > LAST_LINE) begin
                     line_in = '0;
                     mode_in = MODE_OBJ_SCAN;
                     if (oam_irq_en_ff) begin
                        wr  = 1'b1;
                        val = 1'b1;
                     end
                  end
               end
            end
            MODE_OBJ_SCAN: begin
               if (dot_sum >= LEN_OAM) begin
                  dot_in  = '0;
                  mode_in = MODE_XFER;
               end
            end
            MODE_XFER: begin
               if (dot_sum >= LEN_XFER) begin
                  dot_in  = '0;
                  mode_in = MODE_HORZ_BLANK;
                  render  = 1'b1;
                  if (hblank_irq_en_ff) begin
                     wr  = 1'b1;
                     val = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Control and timing state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= MODE_HORZ_BLANK;
         dot_ff       <= '0;
         line_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (out_load) begin
            mode_ff <= mode_in;
            dot_ff  <= dot_in;
            line_ff <= line_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_load) begin
         elapsed_ff <= req_elapsed_cycles;
      end
      if (out_load) begin
         out_mode_ff   <= mode_in;
         out_line_ff   <= line_in;
         out_render_ff <= render;
         out_frame_ff  <= frame;
         out_wr_ff     <= wr;
         out_val_ff    <= val;
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_lcd_mode          = out_mode_ff;
   assign rsp_current_line      = out_line_ff;
   assign rsp_line_render_pulse = out_render_ff;
   assign rsp_frame_done_pulse  = out_frame_ff;
   assign rsp_irq_flag_write    = out_wr_ff;
   assign rsp_irq_flag_value    = out_val_ff;

   // Checks
   a_line_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_current_line <= LAST_LINE))
      else $error("line counter out of range");

   a_frame_entry: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done_pulse) |->
         (rsp_lcd_mode == MODE_VERT_BLANK && rsp_current_line == FIRST_VBLANK_LINE))
      else $error("frame done without vblank entry at first vblank line");

   a_render_hblank: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_line_render_pulse) |-> (rsp_lcd_mode == MODE_HORZ_BLANK))
      else $error("render pulse outside hblank entry");

   a_irq_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_irq_flag_value) |-> rsp_irq_flag_write)
      else $error("interrupt flag value without write");

   a_dot_reset: assert property (@(posedge clock) disable iff (reset)
      (out_load && lcd_enable_ff && mode_in != mode_ff) |=> (dot_ff == '0))
      else $error("dot counter not cleared on mode change");

endmodule

`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lmts_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_LEN   = 60;
   localparam int IDLE_PCT       = 29;

   // One display status item as reported per step
   typedef struct packed {
      lcd_mode_type      mode;
      logic [LINE_W-1:0] line;
      logic              render;
      logic              frame;
      logic              irq_wr;
      logic              irq_val;
   } lcd_status_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [ELAP_W-1:0] req_elapsed_cycles = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [1:0]        rsp_lcd_mode;
   logic [LINE_W-1:0] rsp_current_line;
   logic              rsp_line_render_pulse;
   logic              rsp_frame_done_pulse;
   logic              rsp_irq_flag_write;
   logic              rsp_irq_flag_value;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [7:0]        csr_wdata = '0;

   lcd_mode_timing_sequencer_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_elapsed_cycles    (req_elapsed_cycles),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_lcd_mode          (rsp_lcd_mode),
      .rsp_current_line      (rsp_current_line),
      .rsp_line_render_pulse (rsp_line_render_pulse),
      .rsp_frame_done_pulse  (rsp_frame_done_pulse),
      .rsp_irq_flag_write    (rsp_irq_flag_write),
      .rsp_irq_flag_value    (rsp_irq_flag_value),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // Shadow of the display settings
   logic              cfg_lcd_on, cfg_hblank_irq, cfg_vblank_irq, cfg_oam_irq;
   logic              cfg_line_irq, cfg_match_eq;
   logic [7:0]        cfg_cmp_line;
   // Shadow of the timing state
   lcd_mode_type      mdl_mode;
   logic [DOT_W-1:0]  mdl_dot;
   logic [LINE_W-1:0] mdl_line;

   lcd_status_type pending_status[$];
   lcd_status_type oldest;

   int fails = 0;
   int items_taken = 0;
   int phases_run = 0;
   int frames_seen = 0;
   int lines_drawn = 0;
   int irq_writes_seen = 0;
   int quiet_cycles = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   bit gaps_on = 1'b1;

   // Line advance; the compare sees the new line, even 154 at the end of vblank
   function automatic void advance_line(inout lcd_status_type st);
      mdl_line = mdl_line + 1'b1;
      if (cfg_line_irq) begin
         st.irq_wr  = 1'b1;
         st.irq_val = cfg_match_eq ? (mdl_line == cfg_cmp_line) : (mdl_line != cfg_cmp_line);
      end
   endfunction

   // Predicted status after one step of elapsed cycles
   function automatic lcd_status_type advance_timing(input logic [ELAP_W-1:0] cyc);
      lcd_status_type st;
      st = '0;
      if (!cfg_lcd_on) begin
         // display off: forced vblank, line 0, dots kept
         mdl_mode = MODE_VERT_BLANK;
         mdl_line = '0;
      end else begin
         mdl_dot = mdl_dot + {2'b00, cyc};
         case (mdl_mode)
            MODE_HORZ_BLANK: begin
               if (mdl_dot >= LEN_HBLANK) begin
                  mdl_dot = '0;
                  advance_line(st);
                  if (mdl_line == FIRST_VBLANK_LINE) begin
                     mdl_mode = MODE_VERT_BLANK;
                     st.frame = 1'b1;
                     if (cfg_vblank_irq) begin
                        st.irq_wr  = 1'b1;
                        st.irq_val = 1'b1;
                     end
                  end else begin
                     mdl_mode = MODE_OBJ_SCAN;
                     if (cfg_oam_irq) begin
                        st.irq_wr  = 1'b1;
                        st.irq_val = 1'b1;
                     end
                  end
               end
            end
            MODE_VERT_BLANK: begin
               if (mdl_dot >= LEN_LINE) begin
                  mdl_dot = '0;
                  advance_line(st);
                  if (mdl_line > LAST_LINE) begin
                     mdl_line = '0;
                     mdl_mode = MODE_OBJ_SCAN;
                     if (cfg_oam_irq) begin
                        st.irq_wr  = 1'b1;
                        st.irq_val = 1'b1;
                     end
                  end
               end
            end
            MODE_OBJ_SCAN: begin
               if (mdl_dot >= LEN_OAM) begin
                  mdl_dot  = '0;
                  mdl_mode = MODE_XFER;
               end
            end
            default: begin
               if (mdl_dot >= LEN_XFER) begin
                  mdl_dot   = '0;
                  mdl_mode  = MODE_HORZ_BLANK;
                  st.render = 1'b1;
                  if (cfg_hblank_irq) begin
                     st.irq_wr  = 1'b1;
                     st.irq_val = 1'b1;
                  end
               end
            end
         endcase
      end
      st.mode = mdl_mode;
      st.line = mdl_line;
      return st;
   endfunction

   // Track settings writes and accepted steps
   always @(posedge clock) begin
      if (reset) begin
         cfg_lcd_on     = 1'b0;
         cfg_hblank_irq = 1'b0;
         cfg_vblank_irq = 1'b0;
         cfg_oam_irq    = 1'b0;
         cfg_line_irq   = 1'b0;
         cfg_match_eq   = 1'b0;
         cfg_cmp_line   = '0;
         mdl_mode       = MODE_HORZ_BLANK;
         mdl_dot        = '0;
         mdl_line       = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LCD_ENABLE:        cfg_lcd_on     = csr_wdata[0];
               CSR_HBLANK_IRQ_ENABLE: cfg_hblank_irq = csr_wdata[0];
               CSR_VBLANK_IRQ_ENABLE: cfg_vblank_irq = csr_wdata[0];
               CSR_OAM_IRQ_ENABLE:    cfg_oam_irq    = csr_wdata[0];
               CSR_LINE_IRQ_ENABLE:   cfg_line_irq   = csr_wdata[0];
               CSR_MATCH_ON_EQUAL:    cfg_match_eq   = csr_wdata[0];
               CSR_COMPARE_LINE:      cfg_cmp_line   = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            oldest = advance_timing(req_elapsed_cycles);
            pending_status.insert(pending_status.size(), oldest);
            items_taken++;
            frames_seen     += oldest.frame;
            lines_drawn     += oldest.render;
            irq_writes_seen += oldest.irq_wr;
         end
      end
   end

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endfunction

   // Compare each accepted status item with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            $error("unexpected item: mode %0d line %0d", rsp_lcd_mode, rsp_current_line);
            fails++;
         end else begin
            lcd_status_type want;
            want = pending_status.pop_front();
            check_field("lcd_mode", 8'(want.mode), 8'(rsp_lcd_mode));
            check_field("current_line", want.line, rsp_current_line);
            check_field("line_render_pulse", 8'(want.render), 8'(rsp_line_render_pulse));
            check_field("frame_done_pulse", 8'(want.frame), 8'(rsp_frame_done_pulse));
            check_field("irq_flag_write", 8'(want.irq_wr), 8'(rsp_irq_flag_write));
            check_field("irq_flag_value", 8'(want.irq_val), 8'(rsp_irq_flag_value));
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_served != hold_asked) begin
         hold_served++;
         hold_left = HOLD_OFF_LEN - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   // Watchdog on cycles with no handshake at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout after %0d quiet cycles", quiet_cycles);
            $display("FAIL lcd_mode_timing_sequencer_unit");
            $finish;
         end
      end
   end

   // Offer one step item, with random idle cycles ahead of it
   task automatic send_step(input logic [ELAP_W-1:0] cyc);
      while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_elapsed_cycles <= cyc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drain all outstanding status items
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_display(input bit on, input bit hb, input bit vb, input bit oam,
                              input bit lm, input bit eq, input logic [7:0] cmp);
      wait_idle();
      write_csr(CSR_LCD_ENABLE, {7'd0, on});
      write_csr(CSR_HBLANK_IRQ_ENABLE, {7'd0, hb});
      write_csr(CSR_VBLANK_IRQ_ENABLE, {7'd0, vb});
      write_csr(CSR_OAM_IRQ_ENABLE, {7'd0, oam});
      write_csr(CSR_LINE_IRQ_ENABLE, {7'd0, lm});
      write_csr(CSR_MATCH_ON_EQUAL, {7'd0, eq});
      write_csr(CSR_COMPARE_LINE, cmp);
      phases_run++;
   endtask

   // Mostly long steps so frames go by quickly, with zeros and maxima mixed in
   function automatic logic [ELAP_W-1:0] pick_elapsed();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2, 3: return ELAP_W'($urandom_range(0, 255));
         default: return ELAP_W'($urandom_range(120, 255));
      endcase
   endfunction

   // Display off after reset: forced vblank, line 0
   task automatic test_display_off();
      send_step(8'd0);
      send_step(8'd255);
      send_step(8'd1);
   endtask

   // Enable with every interrupt on, extreme step sizes, off and on again
   task automatic test_enable_and_extremes();
      set_display(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 8'd1);
      send_step(8'd255);
      send_step(8'd255);
      send_step(8'd0);
      send_step(8'd128);
      send_step(8'd1);
      send_step(8'd255);
      send_step(8'd200);
      set_display(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0);
      send_step(8'd255);
      send_step(8'd170);
      set_display(1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'd255);
      send_step(8'd255);
      send_step(8'd255);
      send_step(8'd85);
      send_step(8'd255);
      send_step(8'd255);
   endtask

   // Long receiver hold-off while steps keep coming, so the input backs up
   task automatic test_output_backpressure();
      wait_idle();
      hold_asked++;
      repeat (40) send_step(pick_elapsed());
   endtask

   // Random setting phases; one phase runs with no idling on either side
   task automatic test_random_phases();
      logic [7:0] cmp;
      bit         on, hb, vb, oam, lm, eq;
      int         count;
      for (int ph = 0; ph < 8; ph++) begin
         case ($urandom_range(0, 4))
            0: cmp = 8'd0;
            1: cmp = FIRST_VBLANK_LINE;
            2: cmp = LAST_LINE + 8'd1;
            3: cmp = 8'hFF;
            default: cmp = 8'($urandom_range(0, 153));
         endcase
         on  = (ph != 4);
         hb  = 1'($urandom_range(0, 1));
         vb  = 1'($urandom_range(0, 1));
         oam = 1'($urandom_range(0, 1));
         lm  = 1'($urandom_range(0, 1));
         eq  = 1'($urandom_range(0, 1));
         // all interrupts on, then all off
         if (ph == 0) {hb, vb, oam, lm, eq} = 5'b11111;
         if (ph == 1) {hb, vb, oam, lm, eq} = 5'b00000;
         set_display(on, hb, vb, oam, lm, eq, cmp);
         gaps_on = (ph != 2);
         count   = on ? 190 : 30;
         repeat (count) send_step(pick_elapsed());
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_display_off();
      test_enable_and_extremes();
      test_output_backpressure();
      test_random_phases();
      wait_idle();
      repeat (8) @(posedge clock);
      if (pending_status.size() != 0) begin
         $error("%0d status items never arrived", pending_status.size());
         fails++;
      end
      $display("Ran %0d steps over %0d setting phases, incl. display off and output hold-off",
               items_taken, phases_run);
      $display("Predicted %0d frame ends, %0d lines drawn, %0d interrupt-flag writes",
               frames_seen, lines_drawn, irq_writes_seen);
      if (fails == 0) begin
         $display("PASS lcd_mode_timing_sequencer_unit");
      end else begin
         $display("FAIL lcd_mode_timing_sequencer_unit");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/lmts_pkg.sv
hw/rtl/lcd_mode_timing_sequencer_unit.sv
test/testbench.sv
